// ----- rtl/fhtc_pkg.sv -----
// Package for the file header type classifier: sizes, result codes,
// magic numbers and the substring patterns of the text tests. No dependencies.
package fhtc_pkg;

  localparam int unsigned HEADER_BYTES = 512;
  localparam int unsigned KEEP_BYTES   = 18;
  localparam int unsigned WIN_BYTES    = 9;
  localparam int unsigned PAT_COUNT    = 14;

  typedef logic [KEEP_BYTES-1:0][7:0] hdr_t;
  typedef logic [WIN_BYTES-1:0][7:0]  win_t;
  typedef logic [PAT_COUNT-1:0]       pat_t;

  typedef enum logic [4:0] {
    FC_DATA    = 5'd0,
    FC_MACHO64 = 5'd1,
    FC_MACHO32 = 5'd2,
    FC_FAT     = 5'd3,
    FC_ELF     = 5'd4,
    FC_AR      = 5'd5,
    FC_GZIP    = 5'd6,
    FC_BZIP2   = 5'd7,
    FC_XZ      = 5'd8,
    FC_PNG     = 5'd9,
    FC_JPEG    = 5'd10,
    FC_GIF     = 5'd11,
    FC_PDF     = 5'd12,
    FC_BASH    = 5'd13,
    FC_ZSH     = 5'd14,
    FC_PYTHON  = 5'd15,
    FC_PERL    = 5'd16,
    FC_RUBY    = 5'd17,
    FC_NODE    = 5'd18,
    FC_SCRIPT  = 5'd19,
    FC_XML     = 5'd20,
    FC_HTML    = 5'd21,
    FC_CSRC    = 5'd22,
    FC_JSON    = 5'd23,
    FC_MAKE    = 5'd24,
    FC_TEXT    = 5'd25
  } file_class_e;

  typedef enum logic [2:0] {
    CPU_ARM64   = 3'd0,
    CPU_X86_64  = 3'd1,
    CPU_ARM     = 3'd2,
    CPU_I386    = 3'd3,
    CPU_UNKNOWN = 3'd4
  } cpu_arch_e;

  typedef enum logic [2:0] {
    MK_OBJECT   = 3'd0,
    MK_EXECUTE  = 3'd1,
    MK_DYLIB    = 3'd2,
    MK_DYLINKER = 3'd3,
    MK_BUNDLE   = 3'd4,
    MK_DSYM     = 3'd5,
    MK_OTHER    = 3'd6
  } macho_kind_e;

  typedef enum logic [1:0] {
    EK_GENERIC = 2'd0,
    EK_EXEC    = 2'd1,
    EK_DYN     = 2'd2
  } elf_kind_e;

  typedef struct packed {
    file_class_e cls;
    cpu_arch_e   cpu;
    macho_kind_e kind;
    logic        elf_wide;
    elf_kind_e   elf_kind;
  } res_t;

  localparam logic [31:0] MAGIC_MACHO64    = 32'hfeedfacf;
  localparam logic [31:0] MAGIC_MACHO64_SW = 32'hcffaedfe;
  localparam logic [31:0] MAGIC_MACHO32    = 32'hfeedface;
  localparam logic [31:0] MAGIC_MACHO32_SW = 32'hcefaedfe;
  localparam logic [31:0] MAGIC_FAT        = 32'hcafebabe;
  localparam logic [31:0] MAGIC_FAT_SW     = 32'hbebafeca;
  localparam logic [31:0] MAGIC_ELF        = 32'h464c457f;
  localparam logic [31:0] MAGIC_PNG        = 32'h474e5089;
  localparam logic [15:0] MAGIC_GZIP       = 16'h8b1f;
  localparam logic [15:0] MAGIC_JPEG       = 16'hd8ff;
  localparam logic [31:0] CPU_ID_ARM64     = 32'h0100000c;
  localparam logic [31:0] CPU_ID_X86_64    = 32'h01000007;
  localparam logic [31:0] CPU_ID_ARM       = 32'h0000000c;
  localparam logic [31:0] CPU_ID_I386      = 32'h00000007;

  localparam logic [31:0] MFT_OBJECT   = 32'd1;
  localparam logic [31:0] MFT_EXECUTE  = 32'd2;
  localparam logic [31:0] MFT_DYLIB    = 32'd6;
  localparam logic [31:0] MFT_DYLINKER = 32'd7;
  localparam logic [31:0] MFT_BUNDLE   = 32'd8;
  localparam logic [31:0] MFT_DSYM     = 32'd10;

  localparam logic [15:0] ET_EXEC = 16'd2;
  localparam logic [15:0] ET_DYN  = 16'd3;

  // pattern flag positions
  localparam int unsigned PAT_SH      = 0;
  localparam int unsigned PAT_BASH    = 1;
  localparam int unsigned PAT_ZSH     = 2;
  localparam int unsigned PAT_PYTHON  = 3;
  localparam int unsigned PAT_PERL    = 4;
  localparam int unsigned PAT_RUBY    = 5;
  localparam int unsigned PAT_NODE    = 6;
  localparam int unsigned PAT_INCLUDE = 7;
  localparam int unsigned PAT_MAIN    = 8;
  localparam int unsigned PAT_COLON   = 9;
  localparam int unsigned PAT_COMMA   = 10;
  localparam int unsigned PAT_MAKE    = 11;
  localparam int unsigned PAT_ASSIGN  = 12;
  localparam int unsigned PAT_VAR     = 13;

  // last character sits in byte 0, matching the newest window byte
  localparam win_t PAT_TEXT [PAT_COUNT] = '{
    win_t'("/bin/sh"),  win_t'("/bin/bash"), win_t'("/bin/zsh"), win_t'("python"),
    win_t'("perl"),     win_t'("ruby"),      win_t'("node"),     win_t'("#include"),
    win_t'("int main"), win_t'(":"),         win_t'(","),        win_t'("make"),
    win_t'(":="),       win_t'("$(")
  };

  localparam logic [3:0] PAT_LEN [PAT_COUNT] = '{
    4'd7, 4'd9, 4'd8, 4'd6, 4'd4, 4'd4, 4'd4, 4'd8, 4'd8, 4'd1, 4'd1, 4'd4, 4'd2, 4'd2
  };

endpackage

// ----- rtl/fhtc_classify.sv -----
// Final decision of the file header type classifier: magic numbers, Mach-O
// and ELF fields, text test and text kinds. Depends on fhtc_pkg.
module fhtc_classify #(
  parameter int unsigned HeaderBytes = fhtc_pkg::HEADER_BYTES
) (
  input  fhtc_pkg::hdr_t                   hdr_i,
  input  logic [$clog2(HeaderBytes+1)-1:0] cnt_i,
  input  logic [$clog2(HeaderBytes+1)-1:0] prn_i,
  input  logic                             nul_i,
  input  fhtc_pkg::pat_t                   seen_i,
  output fhtc_pkg::res_t                   res_o
);
  import fhtc_pkg::*;

  localparam int unsigned CntW = $clog2(HeaderBytes + 1);
  localparam int unsigned MulW = CntW + 7;

  logic [31:0]     magic;
  logic [31:0]     cpu_le;
  logic [31:0]     kind_le;
  logic [31:0]     cpu;
  logic [31:0]     kind;
  logic [63:0]     lead;
  logic [15:0]     etype;
  logic            swapped;
  logic            is_text;
  logic [MulW-1:0] prn_x100;
  logic [MulW-1:0] cnt_x91;
  file_class_e     text_cls;
  cpu_arch_e       cpu_code;
  macho_kind_e     kind_code;

  assign magic   = {hdr_i[3], hdr_i[2], hdr_i[1], hdr_i[0]};
  assign cpu_le  = {hdr_i[7], hdr_i[6], hdr_i[5], hdr_i[4]};
  assign kind_le = {hdr_i[15], hdr_i[14], hdr_i[13], hdr_i[12]};
  assign lead    = {hdr_i[0], hdr_i[1], hdr_i[2], hdr_i[3],
                    hdr_i[4], hdr_i[5], hdr_i[6], hdr_i[7]};
  assign etype   = {hdr_i[17], hdr_i[16]};
  assign swapped = (magic == MAGIC_MACHO64_SW) || (magic == MAGIC_MACHO32_SW);
  assign cpu     = swapped ? {hdr_i[4], hdr_i[5], hdr_i[6], hdr_i[7]} : cpu_le;
  assign kind    = swapped ? {hdr_i[12], hdr_i[13], hdr_i[14], hdr_i[15]} : kind_le;

  // floor(p*100/n) > 90 is p*100 >= n*91
  assign prn_x100 = MulW'(prn_i) * MulW'(100);
  assign cnt_x91  = MulW'(cnt_i) * MulW'(91);
  assign is_text  = !nul_i && (prn_x100 >= cnt_x91);

  always_comb begin
    case (cpu)
      CPU_ID_ARM64:  cpu_code = CPU_ARM64;
      CPU_ID_X86_64: cpu_code = CPU_X86_64;
      CPU_ID_ARM:    cpu_code = CPU_ARM;
      CPU_ID_I386:   cpu_code = CPU_I386;
      default:       cpu_code = CPU_UNKNOWN;
    endcase
    case (kind)
      MFT_OBJECT:   kind_code = MK_OBJECT;
      MFT_EXECUTE:  kind_code = MK_EXECUTE;
      MFT_DYLIB:    kind_code = MK_DYLIB;
      MFT_DYLINKER: kind_code = MK_DYLINKER;
      MFT_BUNDLE:   kind_code = MK_BUNDLE;
      MFT_DSYM:     kind_code = MK_DSYM;
      default:      kind_code = MK_OTHER;
    endcase
  end

  always_comb begin
    if (lead[63:48] == "#!") begin
      if (seen_i[PAT_SH] || seen_i[PAT_BASH]) text_cls = FC_BASH;
      else if (seen_i[PAT_ZSH])               text_cls = FC_ZSH;
      else if (seen_i[PAT_PYTHON])            text_cls = FC_PYTHON;
      else if (seen_i[PAT_PERL])              text_cls = FC_PERL;
      else if (seen_i[PAT_RUBY])              text_cls = FC_RUBY;
      else if (seen_i[PAT_NODE])              text_cls = FC_NODE;
      else                                    text_cls = FC_SCRIPT;
    end else if (cnt_i >= CntW'(5) && lead[63:24] == "<?xml") begin
      text_cls = FC_XML;
    end else if (cnt_i >= CntW'(6) &&
                 (lead[63:24] == "<html" || lead[63:24] == "<!DOC")) begin
      text_cls = FC_HTML;
    end else if (seen_i[PAT_INCLUDE] || seen_i[PAT_MAIN]) begin
      text_cls = FC_CSRC;
    end else if ((hdr_i[0] == "{" || hdr_i[0] == "[") &&
                 (seen_i[PAT_COLON] || seen_i[PAT_COMMA])) begin
      text_cls = FC_JSON;
    end else if (seen_i[PAT_MAKE] || seen_i[PAT_ASSIGN] || seen_i[PAT_VAR]) begin
      text_cls = FC_MAKE;
    end else begin
      text_cls = FC_TEXT;
    end
  end

  always_comb begin
    res_o = '{cls: FC_DATA, cpu: CPU_ARM64, kind: MK_OBJECT, elf_wide: 1'b0,
              elf_kind: EK_GENERIC};
    if (cnt_i < CntW'(4)) begin
      res_o.cls = FC_DATA;
    end else if (magic == MAGIC_MACHO64 || magic == MAGIC_MACHO64_SW) begin
      res_o.cls  = FC_MACHO64;
      res_o.cpu  = cpu_code;
      res_o.kind = kind_code;
    end else if (magic == MAGIC_MACHO32 || magic == MAGIC_MACHO32_SW) begin
      res_o.cls  = FC_MACHO32;
      res_o.cpu  = cpu_code;
      res_o.kind = kind_code;
    end else if (magic == MAGIC_FAT || magic == MAGIC_FAT_SW) begin
      res_o.cls = FC_FAT;
    end else if (magic == MAGIC_ELF) begin
      res_o.cls      = FC_ELF;
      res_o.elf_wide = (hdr_i[4] == 8'd2);
      res_o.elf_kind = (etype == ET_EXEC) ? EK_EXEC :
                       (etype == ET_DYN)  ? EK_DYN  : EK_GENERIC;
    end else if (cnt_i >= CntW'(8) && lead == {"!<arch>", 8'h0a}) begin
      res_o.cls = FC_AR;
    end else if (magic[15:0] == MAGIC_GZIP) begin
      res_o.cls = FC_GZIP;
    end else if (lead[63:40] == "BZh") begin
      res_o.cls = FC_BZIP2;
    end else if (cnt_i >= CntW'(6) && lead[63:24] == {8'hfd, "7zXZ"}) begin
      res_o.cls = FC_XZ;
    end else if (magic == MAGIC_PNG) begin
      res_o.cls = FC_PNG;
    end else if (magic[15:0] == MAGIC_JPEG) begin
      res_o.cls = FC_JPEG;
    end else if (lead[63:32] == "GIF8") begin
      res_o.cls = FC_GIF;
    end else if (lead[63:32] == "%PDF") begin
      res_o.cls = FC_PDF;
    end else if (is_text) begin
      res_o.cls = text_cls;
    end
  end

endmodule

// ----- rtl/file_header_type_classifier.sv -----
// Top level of the file header type classifier: byte scanner state, input
// and result registers. Depends on fhtc_pkg and fhtc_classify.
//
// Usage: the file's leading bytes arrive in order on the input channel
// (byte_value_i, last_byte_i, in_valid_i, in_stall_o), one byte per request.
// The byte flagged last_byte_i closes the file and yields one result request
// on the output channel (file_class_o, cpu_arch_o, macho_kind_o, elf_wide_o,
// elf_kind_o, out_valid_o, out_stall_i); other bytes yield none.
// Bytes after the first HeaderBytes of a file are ignored apart from their
// last flag. All scan state clears after the closing byte, so the next file
// may follow at once.
// The closing byte goes through the input register, then its result into the
// result register. Throughput: one byte per cycle while the input does not
// stall; each byte updates counters, the 9-byte window and the match flags.
// Reset clears the valid flags of both registers and all scan state; no result is pending.
// A stalled result holds; bytes of the next file are still taken until a
// second closing byte meets the occupied result register, which then stalls
// the input.
module file_header_type_classifier #(
  parameter int unsigned HeaderBytes = fhtc_pkg::HEADER_BYTES
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] byte_value_i,
  input  logic       last_byte_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [4:0] file_class_o,
  output logic [2:0] cpu_arch_o,
  output logic [2:0] macho_kind_o,
  output logic       elf_wide_o,
  output logic [1:0] elf_kind_o
);
  import fhtc_pkg::*;

  localparam int unsigned CntW = $clog2(HeaderBytes + 1);

  logic            a_valid_q;
  logic            a_last_q;
  logic [7:0]      a_byte_q;
  logic            adv;
  logic            fire;
  logic            take;

  logic [CntW-1:0] cnt_q, cnt_d;
  logic [CntW-1:0] prn_q, prn_d;
  logic            nul_q, nul_d;
  hdr_t            hdr_q, hdr_d;
  win_t            win_q, win_d;
  pat_t            seen_q, seen_d;
  logic            hit;

  res_t            res;
  res_t            out_q;
  logic            out_valid_q;

  assign adv        = !a_valid_q || !a_last_q || !out_valid_q || !out_stall_i;
  assign fire       = a_valid_q && adv;
  assign in_stall_o = !adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
      a_last_q  <= 1'b0;
    end else if (adv) begin
      a_valid_q <= in_valid_i;
      a_last_q  <= in_valid_i && last_byte_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv && in_valid_i) begin
      a_byte_q <= byte_value_i;
    end
  end

  // scan update for the byte in the input register
  assign take = (cnt_q < CntW'(HeaderBytes));

  always_comb begin
    cnt_d  = cnt_q;
    prn_d  = prn_q;
    nul_d  = nul_q;
    hdr_d  = hdr_q;
    win_d  = win_q;
    seen_d = seen_q;
    hit    = 1'b0;
    if (take) begin
      for (int unsigned i = 0; i < KEEP_BYTES; i++) begin
        if (cnt_q == CntW'(i)) begin
          hdr_d[i] = a_byte_q;
        end
      end
      cnt_d = cnt_q + CntW'(1);
      if ((a_byte_q >= 8'h20 && a_byte_q <= 8'h7e) || a_byte_q == 8'h0a ||
          a_byte_q == 8'h0d || a_byte_q == 8'h09) begin
        prn_d = prn_q + CntW'(1);
      end else if (a_byte_q == 8'h00) begin
        nul_d = 1'b1;
      end
      win_d = {win_q[WIN_BYTES-2:0], a_byte_q};
      for (int unsigned k = 0; k < PAT_COUNT; k++) begin
        hit = (cnt_d >= CntW'(PAT_LEN[k]));
        for (int unsigned i = 0; i < WIN_BYTES; i++) begin
          if (i < PAT_LEN[k] && win_d[i] != PAT_TEXT[k][i]) begin
            hit = 1'b0;
          end
        end
        if (hit) begin
          seen_d[k] = 1'b1;
        end
      end
    end
  end

  fhtc_classify #(
    .HeaderBytes(HeaderBytes)
  ) u_classify (
    .hdr_i (hdr_d),
    .cnt_i (cnt_d),
    .prn_i (prn_d),
    .nul_i (nul_d),
    .seen_i(seen_d),
    .res_o (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      prn_q  <= '0;
      nul_q  <= 1'b0;
      hdr_q  <= '0;
      win_q  <= '0;
      seen_q <= '0;
    end else if (fire) begin
      if (a_last_q) begin
        cnt_q  <= '0;
        prn_q  <= '0;
        nul_q  <= 1'b0;
        hdr_q  <= '0;
        win_q  <= '0;
        seen_q <= '0;
      end else begin
        cnt_q  <= cnt_d;
        prn_q  <= prn_d;
        nul_q  <= nul_d;
        hdr_q  <= hdr_d;
        win_q  <= win_d;
        seen_q <= seen_d;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (fire && a_last_q) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire && a_last_q) begin
      out_q <= res;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign file_class_o = out_q.cls;
  assign cpu_arch_o   = out_q.cpu;
  assign macho_kind_o = out_q.kind;
  assign elf_wide_o   = out_q.elf_wide;
  assign elf_kind_o   = out_q.elf_kind;

endmodule
